### sv/ptt_pkg.sv
// ---------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the properties text tokenizer.
// ---------------------------------------------------------------------------
package ptt_pkg;

   // parse phases, one-hot
   typedef enum logic [10:0] {
      PH_IDLE    = 11'b000_0000_0001,
      PH_COMMENT = 11'b000_0000_0010,
      PH_KEY     = 11'b000_0000_0100,
      PH_PRESEP  = 11'b000_0000_1000,
      PH_POSTSEP = 11'b000_0001_0000,
      PH_VALUE   = 11'b000_0010_0000,
      PH_ESC     = 11'b000_0100_0000,
      PH_ESCCR   = 11'b000_1000_0000,
      PH_CONT    = 11'b001_0000_0000,
      PH_USKIP   = 11'b010_0000_0000,
      PH_UHEX    = 11'b100_0000_0000
   } phase_type;

   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] ch;
      logic        bad;
   } token_type;

   // one or two tokens caused by one input byte
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### sv/ptt_front.sv
// ---------------------------------------------------------------------------
// ptt_front
// Accepts text bytes, runs the parse state machine and pushes the tokens
// caused by each byte into the queue as one entry.
// ---------------------------------------------------------------------------
module ptt_front import ptt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // in_byte
   input  logic         req_tlast,   // is_last
   input  q_status_type q_status,
   output logic         q_push,
   output entry_type    q_wdata
);

   typedef struct packed {
      phase_type phase;
      logic      emit;
      token_type tok;
   } step_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;

   step_type    st, hex_st;
   logic [15:0] hex_acc, acc_sh;
   logic [2:0]  hex_cnt, cnt_inc;
   logic        hex_ok;
   logic [3:0]  hex_digit;
   logic        eoe, accept;
   logic [7:0]  b;
   token_type   eoe_tok;

   function automatic logic is_eol(input logic [7:0] c);
      return (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic token_type mk_tok(input logic [1:0] k, input logic [15:0] c,
                                        input logic bd);
      token_type t;
      t.kind = k;
      t.ch   = c;
      t.bad  = bd;
      return t;
   endfunction

   function automatic step_type value_byte(input logic [7:0] c);
      step_type s;
      s.phase = PH_VALUE;
      s.emit  = 1'b0;
      s.tok   = mk_tok(KIND_VALUE, {8'd0, c}, 1'b0);
      if (is_eol(c)) begin
         s.phase = PH_IDLE;
         s.emit  = 1'b1;
         s.tok   = mk_tok(KIND_END, 16'd0, 1'b0);
      end else if (c == CH_BSL) begin
         s.phase = PH_ESC;
      end else begin
         s.emit = 1'b1;
      end
      return s;
   endfunction

   function automatic step_type key_byte(input logic [7:0] c);
      step_type s;
      s.phase = PH_KEY;
      s.emit  = 1'b0;
      s.tok   = mk_tok(KIND_KEY, {8'd0, c}, 1'b0);
      if ((c == CH_EQ) || (c == CH_COLON)) begin
         s.phase = PH_POSTSEP;
      end else if (is_blank(c)) begin
         s.phase = PH_PRESEP;
      end else if (is_eol(c)) begin
         s.phase = PH_IDLE;
         s.emit  = 1'b1;
         s.tok   = mk_tok(KIND_END, 16'd0, 1'b0);
      end else begin
         s.emit = 1'b1;
      end
      return s;
   endfunction

   assign b          = req_tdata;
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   // hex digit decode
   always_comb begin
      hex_ok    = 1'b1;
      hex_digit = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         hex_digit = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         hex_digit = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         hex_digit = 4'(b - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // one byte of a unicode escape
   always_comb begin
      acc_sh       = {acc_ff[11:0], hex_digit};
      cnt_inc      = cnt_ff + 3'd1;
      hex_st.phase = PH_UHEX;
      hex_st.emit  = 1'b0;
      hex_st.tok   = mk_tok(KIND_VALUE, acc_sh, 1'b0);
      hex_acc      = acc_sh;
      hex_cnt      = cnt_inc;
      if (!hex_ok) begin
         hex_acc     = 16'd0;
         hex_cnt     = 3'd0;
         hex_st.emit = 1'b1;
         if (is_eol(b)) begin
            hex_st.phase = PH_IDLE;
            hex_st.tok   = mk_tok(KIND_END, 16'd0, 1'b1);
         end else begin
            hex_st.phase = PH_VALUE;
            hex_st.tok   = mk_tok(KIND_VALUE, {8'd0, b}, 1'b1);
         end
      end else if (cnt_inc >= 3'd4) begin
         hex_st.phase = PH_VALUE;
         hex_st.emit  = 1'b1;
         hex_acc      = 16'd0;
         hex_cnt      = 3'd0;
      end
   end

   always_comb begin
      st.phase = phase_ff;
      st.emit  = 1'b0;
      st.tok   = mk_tok(KIND_VALUE, {8'd0, b}, 1'b0);
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      case (phase_ff)
         PH_COMMENT: begin
            if (is_eol(b)) st.phase = PH_IDLE;
         end
         PH_KEY: begin
            st = key_byte(b);
         end
         PH_PRESEP: begin
            if ((b == CH_EQ) || (b == CH_COLON)) begin
               st.phase = PH_POSTSEP;
            end else if (!is_blank(b)) begin
               st = value_byte(b);
            end
         end
         PH_POSTSEP, PH_CONT: begin
            if (!is_blank(b)) st = value_byte(b);
         end
         PH_VALUE: begin
            st = value_byte(b);
         end
         PH_ESC: begin
            if (b == CH_CR) begin
               st.phase = PH_ESCCR;
            end else if (b == CH_LF) begin
               st.phase = PH_CONT;
            end else if (b == CH_U) begin
               acc_in   = 16'd0;
               cnt_in   = 3'd0;
               st.phase = PH_USKIP;
            end else begin
               st.phase = PH_VALUE;
               st.emit  = 1'b1;
               if (b == CH_T)      st.tok.ch = {8'd0, CH_TAB};
               else if (b == CH_N) st.tok.ch = {8'd0, CH_LF};
               else if (b == CH_R) st.tok.ch = {8'd0, CH_CR};
            end
         end
         PH_ESCCR: begin
            if ((b == CH_LF) || is_blank(b)) st.phase = PH_CONT;
            else                             st = value_byte(b);
         end
         PH_USKIP: begin
            // repeated u after the backslash is skipped
            if (b != CH_U) begin
               st     = hex_st;
               acc_in = hex_acc;
               cnt_in = hex_cnt;
            end
         end
         PH_UHEX: begin
            st     = hex_st;
            acc_in = hex_acc;
            cnt_in = hex_cnt;
         end
         default: begin
            if ((b == CH_HASH) || (b == CH_BANG)) begin
               st.phase = PH_COMMENT;
            end else if (is_eol(b) || is_blank(b)) begin
               st.phase = PH_IDLE;
            end else begin
               st = key_byte(b);
            end
         end
      endcase

      // end of file closes an open entry
      eoe      = req_tlast && (st.phase != PH_IDLE) && (st.phase != PH_COMMENT);
      phase_in = st.phase;
      if (req_tlast) begin
         phase_in = PH_IDLE;
         acc_in   = 16'd0;
         cnt_in   = 3'd0;
      end
   end

   assign eoe_tok      = mk_tok(KIND_END, 16'd0, 1'b0);
   assign q_push       = accept && (st.emit || eoe);
   assign q_wdata.two  = st.emit && eoe;
   assign q_wdata.tok0 = st.emit ? st.tok : eoe_tok;
   assign q_wdata.tok1 = eoe_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= 16'd0;
         cnt_ff   <= 3'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### sv/ptt_queue.sv
// ---------------------------------------------------------------------------
// ptt_queue
// Short queue of token entries between the parser and the output stage.
// ---------------------------------------------------------------------------
module ptt_queue import ptt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    wdata,
   input  logic         pop,
   output entry_type    rdata,
   output q_status_type status
);

   entry_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]      cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign status.full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rdata        = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= wdata;
   end

endmodule

### sv/ptt_back.sv
// ---------------------------------------------------------------------------
// ptt_back
// Output stage: takes queue entries apart into single tokens and holds
// each in the output register until the receiver takes it.
// ---------------------------------------------------------------------------
module ptt_back import ptt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  entry_type    q_rdata,
   input  q_status_type q_status,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // char_value
   output logic [2:0]   rsp_tuser,   // token_kind [1:0], bad_escape [2]
   output logic         rsp_tlast    // last_in_run
);

   logic        valid_ff, valid_in;
   logic [15:0] data_ff;
   logic [2:0]  user_ff;
   logic        last_ff;
   logic        sel_ff, sel_in;
   logic        load, fin;
   token_type   cur;

   assign load  = !valid_ff || rsp_tready;
   assign cur   = sel_ff ? q_rdata.tok1 : q_rdata.tok0;
   // second token of the entry, or the only one
   assign fin   = !q_rdata.two || sel_ff;
   assign q_pop = load && !q_status.empty && fin;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) sel_in = !fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !q_status.empty) begin
         data_ff <= cur.ch;
         user_ff <= {cur.bad, cur.kind};
         last_ff <= fin;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

### sv/properties_text_tokenizer.sv
// ---------------------------------------------------------------------------
// properties_text_tokenizer
// Splits a properties text into key characters, value characters and
// end-of-entry marks, one input byte per cycle while the queue has room.
// ---------------------------------------------------------------------------
// usage
//   req: one text byte per transaction in tdata, tlast on the final byte of
//   the file (closes any open entry and returns the parser to between entries)
//   rsp: one token per transaction, char_value in tdata, token_kind and
//   bad_escape in tuser, tlast on the final token caused by one input byte
//   a byte causes zero, one or two tokens
// timing
//   the parser takes one byte per cycle as long as its four-entry queue has
//   room; while rsp_tready is high the queue empties at one token per cycle,
//   so bytes that cause two tokens let the queue fill and briefly hold off
//   req_tready; tokens go through the queue memory, then the output register
// reset
//   synchronous; clears the parse state, the queue and the output valid flag
// stall
//   a token waits in the output register while rsp_tready is low; the parser
//   keeps accepting bytes until the queue is full
// ---------------------------------------------------------------------------
module properties_text_tokenizer import ptt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // char_value
   output logic [2:0]  rsp_tuser,   // token_kind [1:0], bad_escape [2]
   output logic        rsp_tlast    // last_in_run
);

   q_status_type q_status;
   logic         q_push, q_pop;
   entry_type    q_wdata, q_rdata;

   ptt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   ptt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   ptt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_rdata    (q_rdata),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
